@@ design/esc_tfp_pkg.sv @@
// shared types, constants and crc helper for the esc telemetry frame parser
// no dependencies; imported by every module of the parser
package esc_tfp_pkg;

  localparam int NUM_CODES  = 5;
  localparam int CODE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int MOTORS     = 4;
  localparam int ADDR_W     = 5;
  localparam int CNT_W      = 4;

  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam logic [CNT_W-1:0] LEN_ERPM_ONLY = 4'd10;
  localparam logic [CNT_W-1:0] LEN_TEMP      = 4'd11;
  localparam logic [CNT_W-1:0] LEN_WORD      = 4'd12;

  // byte positions inside a frame
  localparam logic [CNT_W-1:0] POS_LAST_ERPM = 4'd8;
  localparam logic [CNT_W-1:0] POS_EXTRA_HI  = 4'd9;

  // register index in the config space
  typedef enum logic [2:0] {
    REG_CODE_ERPM   = 3'd0,
    REG_CODE_TEMP   = 3'd1,
    REG_CODE_VOLT   = 3'd2,
    REG_CODE_CURR   = 3'd3,
    REG_CODE_CHARGE = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_ERPM   = 3'd0,
    KIND_TEMP   = 3'd1,
    KIND_VOLT   = 3'd2,
    KIND_CURR   = 3'd3,
    KIND_CHARGE = 3'd4
  } kind_t;

  typedef logic [NUM_CODES-1:0][CODE_W-1:0] codes_t;

  typedef struct packed {
    logic                           frame_ok;
    logic                           crc_error;
    logic [MOTORS-1:0][WORD_W-1:0]  erpm;
    logic [WORD_W-1:0]              erpm_mean;
    logic [7:0]                     temperature;
    logic [WORD_W-1:0]              voltage;
    logic [WORD_W-1:0]              current;
    logic [WORD_W-1:0]              charge;
  } result_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] frame_len(input kind_t kind);
    logic [CNT_W-1:0] len;
    case (kind)
      KIND_ERPM: len = LEN_ERPM_ONLY;
      KIND_TEMP: len = LEN_TEMP;
      default:   len = LEN_WORD;
    endcase
    return len;
  endfunction

endpackage

@@ design/esc_tfp_regs.sv @@
// apb-style config registers holding the five frame type codes
// depends on esc_tfp_pkg
module esc_tfp_regs
  import esc_tfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output codes_t            codes
);

  codes_t     codes_r;
  codes_t     codes_nxt;
  reg_idx_t   idx;
  logic       wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign codes      = codes_r;

  always_comb begin
    codes_nxt  = codes_r;
    cfg_prdata = '0;
    unique case (idx) inside
      REG_CODE_ERPM, REG_CODE_TEMP, REG_CODE_VOLT, REG_CODE_CURR, REG_CODE_CHARGE: begin
        cfg_prdata = {24'd0, codes_r[idx]};
        if (wr_en) begin
          codes_nxt[idx] = cfg_pwdata[CODE_W-1:0];
        end
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r[REG_CODE_ERPM]   <= 8'd1;
      codes_r[REG_CODE_TEMP]   <= 8'd2;
      codes_r[REG_CODE_VOLT]   <= 8'd3;
      codes_r[REG_CODE_CURR]   <= 8'd4;
      codes_r[REG_CODE_CHARGE] <= 8'd5;
    end else begin
      codes_r <= codes_nxt;
    end
  end

endmodule

@@ design/esc_tfp_core.sv @@
// frame state, running crc, staging and held telemetry registers
// depends on esc_tfp_pkg; updated once per item on the fire strobe
module esc_tfp_core
  import esc_tfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  input  codes_t     codes,
  output result_t    res
);

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              len_r, len_nxt;
  kind_t                         kind_r, kind_nxt;
  logic [7:0]                    crc_r, crc_nxt;
  logic [MOTORS-1:0][WORD_W-1:0] staged_erpm_r, staged_erpm_nxt;
  logic [WORD_W-1:0]             staged_extra_r, staged_extra_nxt;
  result_t                       res_r, res_nxt;

  logic                          hit;
  kind_t                         hit_kind;
  logic                          last_byte;
  logic [CNT_W-1:0]              pos_m1;
  logic [1:0]                    motor;
  logic [WORD_W+1:0]             staged_sum;

  // first matching code wins; a zero code never matches
  always_comb begin
    hit      = 1'b0;
    hit_kind = KIND_ERPM;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (codes[i] != '0 && codes[i] == rx_byte) begin
        hit      = 1'b1;
        hit_kind = kind_t'(i[2:0]);
      end
    end
  end

  assign last_byte  = ({1'b0, count_r} + 5'd1) >= {1'b0, len_r};
  assign pos_m1     = count_r - 4'd1;
  assign motor      = pos_m1[2:1];
  assign staged_sum = {2'b00, staged_erpm_r[0]} + {2'b00, staged_erpm_r[1]}
                    + {2'b00, staged_erpm_r[2]} + {2'b00, staged_erpm_r[3]};

  always_comb begin
    count_nxt        = count_r;
    len_nxt          = len_r;
    kind_nxt         = kind_r;
    crc_nxt          = crc_r;
    staged_erpm_nxt  = staged_erpm_r;
    staged_extra_nxt = staged_extra_r;
    res_nxt          = res_r;
    res_nxt.frame_ok  = 1'b0;
    res_nxt.crc_error = 1'b0;

    if (count_r == '0) begin
      if (hit) begin
        kind_nxt  = hit_kind;
        len_nxt   = frame_len(hit_kind);
        crc_nxt   = crc8_step(CRC_INIT, rx_byte);
        count_nxt = 4'd1;
      end
    end else if (last_byte) begin
      if (rx_byte == crc_r) begin
        res_nxt.frame_ok  = 1'b1;
        res_nxt.erpm      = staged_erpm_r;
        res_nxt.erpm_mean = staged_sum[WORD_W+1:2];
        case (kind_r)
          KIND_TEMP:   res_nxt.temperature = staged_extra_r[7:0];
          KIND_VOLT:   res_nxt.voltage     = staged_extra_r;
          KIND_CURR:   res_nxt.current     = staged_extra_r;
          KIND_CHARGE: res_nxt.charge      = staged_extra_r;
          default:     ;
        endcase
      end else begin
        res_nxt.crc_error = 1'b1;
      end
      count_nxt = '0;
    end else begin
      crc_nxt = crc8_step(crc_r, rx_byte);
      if (count_r <= POS_LAST_ERPM) begin
        // odd positions carry the high byte of a motor word
        if (count_r[0]) begin
          staged_erpm_nxt[motor][15:8] = rx_byte;
        end else begin
          staged_erpm_nxt[motor][7:0] = rx_byte;
        end
      end else if (count_r == POS_EXTRA_HI) begin
        staged_extra_nxt = {8'd0, rx_byte};
      end else begin
        staged_extra_nxt = {staged_extra_r[7:0], rx_byte};
      end
      count_nxt = count_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      len_r   <= '0;
      kind_r  <= KIND_ERPM;
      crc_r   <= CRC_INIT;
      res_r   <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
      kind_r  <= kind_nxt;
      crc_r   <= crc_nxt;
      res_r   <= res_nxt;
    end
  end

  // staging has no reset: every word is written within a frame before use
  always_ff @(posedge clk) begin
    if (fire) begin
      staged_erpm_r  <= staged_erpm_nxt;
      staged_extra_r <= staged_extra_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ design/esc_telemetry_frame_parser.sv @@
// esc telemetry frame parser: one received byte in, one telemetry snapshot out.
// an accepted item passes through the input register, then the result register.
// one item per cycle while out_ready is high, set by the input and result registers.
// rst_n is synchronous, active low: hunting state, held values zero, codes 1..5.
// input register and handshake here; depends on esc_tfp_pkg, esc_tfp_regs, esc_tfp_core
module esc_telemetry_frame_parser
  import esc_tfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_frame_ok,
  output logic              out_crc_error,
  output logic [15:0]       out_erpm_first,
  output logic [15:0]       out_erpm_second,
  output logic [15:0]       out_erpm_third,
  output logic [15:0]       out_erpm_fourth,
  output logic [15:0]       out_erpm_mean,
  output logic [7:0]        out_temperature_out,
  output logic [15:0]       out_voltage_out,
  output logic [15:0]       out_current_out,
  output logic [15:0]       out_charge_out,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r, out_valid_nxt;
  logic       fire;
  codes_t     codes;
  result_t    res;

  esc_tfp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .codes       (codes)
  );

  esc_tfp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (in_byte_r),
    .codes   (codes),
    .res     (res)
  );

  // the held item moves into the result register when that slot frees up
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_ok        = res.frame_ok;
  assign out_crc_error       = res.crc_error;
  assign out_erpm_first      = res.erpm[0];
  assign out_erpm_second     = res.erpm[1];
  assign out_erpm_third      = res.erpm[2];
  assign out_erpm_fourth     = res.erpm[3];
  assign out_erpm_mean       = res.erpm_mean;
  assign out_temperature_out = res.temperature;
  assign out_voltage_out     = res.voltage;
  assign out_current_out     = res.current;
  assign out_charge_out      = res.charge;

  logic [17:0] chk_sum;
  assign chk_sum = {2'b00, out_erpm_first} + {2'b00, out_erpm_second}
                 + {2'b00, out_erpm_third} + {2'b00, out_erpm_fourth};

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_ok && out_crc_error))
    else $error("frame_ok and crc_error both set");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_erpm_first) && $stable(out_erpm_mean)
                                   && $stable(out_voltage_out) && $stable(out_frame_ok)))
    else $error("result changed while stalled");

  a_mean_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_erpm_mean == chk_sum[17:2]))
    else $error("held mean disagrees with held erpm values");

endmodule
